### design/setalm_pkg.sv
package setalm_pkg;

   // Default widths of the temperature and tick-count paths.
   localparam int TEMP_BITS_DEFAULT = 12;
   localparam int TICK_BITS_DEFAULT = 16;

   // Monitor state codes, as reported in the result.
   localparam int STATE_BITS = 3;
   localparam logic [STATE_BITS-1:0] ST_ABOVE      = 3'd0;
   localparam logic [STATE_BITS-1:0] ST_LOW        = 3'd1;
   localparam logic [STATE_BITS-1:0] ST_ACTIVATE   = 3'd2;
   localparam logic [STATE_BITS-1:0] ST_LOW_WAIT   = 3'd3;
   localparam logic [STATE_BITS-1:0] ST_DEACTIVATE = 3'd4;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETPOINT       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_DELAY  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALERT_DELAY    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLEAR_DELAY    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_INTERVAL = 3'd4;

   // Result of one tick, packed with the first field in the top bits.
   typedef struct packed {
      logic [STATE_BITS-1:0] state_code;
      logic                  alarm_active;
      logic                  alert_led;
      logic                  relay_closed;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);
   localparam int RSP_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### design/setalm_csr.sv
module setalm_csr #(
   parameter int TEMP_BITS = setalm_pkg::TEMP_BITS_DEFAULT,
   parameter int TICK_BITS = setalm_pkg::TICK_BITS_DEFAULT,
   parameter int CSR_DATA_BITS = (TEMP_BITS > TICK_BITS) ? TEMP_BITS : TICK_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [setalm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]              csr_wdata,
   output logic [TEMP_BITS-1:0]                  setpoint,
   output logic [TICK_BITS-1:0]                  initial_delay,
   output logic [TICK_BITS-1:0]                  alert_delay,
   output logic [TICK_BITS-1:0]                  clear_delay,
   output logic [TICK_BITS-1:0]                  blink_interval,
   output logic                                  initial_delay_wr
);
   import setalm_pkg::*;

   logic [TEMP_BITS-1:0] setpoint_ff;
   logic [TICK_BITS-1:0] initial_delay_ff;
   logic [TICK_BITS-1:0] alert_delay_ff;
   logic [TICK_BITS-1:0] clear_delay_ff;
   logic [TICK_BITS-1:0] blink_interval_ff;

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff       <= '0;
         initial_delay_ff  <= '0;
         alert_delay_ff    <= '0;
         clear_delay_ff    <= '0;
         blink_interval_ff <= {{(TICK_BITS-1){1'b0}}, 1'b1};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT:       setpoint_ff       <= csr_wdata[TEMP_BITS-1:0];
            CSR_INITIAL_DELAY:  initial_delay_ff  <= csr_wdata[TICK_BITS-1:0];
            CSR_ALERT_DELAY:    alert_delay_ff    <= csr_wdata[TICK_BITS-1:0];
            CSR_CLEAR_DELAY:    clear_delay_ff    <= csr_wdata[TICK_BITS-1:0];
            CSR_BLINK_INTERVAL: blink_interval_ff <= csr_wdata[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign setpoint       = setpoint_ff;
   assign alert_delay    = alert_delay_ff;
   assign clear_delay    = clear_delay_ff;
   assign blink_interval = blink_interval_ff;

   // The core reloads its pending delay on this strobe in the initial phase unless it steps.
   assign initial_delay_wr = csr_we && (csr_index == CSR_INITIAL_DELAY);

   // During a write of the initial delay the new value is passed straight through.
   assign initial_delay = initial_delay_wr ? csr_wdata[TICK_BITS-1:0] : initial_delay_ff;

endmodule

### design/setalm_core.sv
module setalm_core #(
   parameter int TEMP_BITS = setalm_pkg::TEMP_BITS_DEFAULT,
   parameter int TICK_BITS = setalm_pkg::TICK_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         sample_valid,
   input  logic [TEMP_BITS-1:0]         temperature,
   input  logic [TEMP_BITS-1:0]         setpoint,
   input  logic [TICK_BITS-1:0]         initial_delay,
   input  logic [TICK_BITS-1:0]         alert_delay,
   input  logic [TICK_BITS-1:0]         clear_delay,
   input  logic [TICK_BITS-1:0]         blink_interval,
   input  logic                         initial_delay_wr,
   output setalm_pkg::result_type       result
);
   import setalm_pkg::*;

   localparam logic [TICK_BITS-1:0] TICK_ONE = {{(TICK_BITS-1){1'b0}}, 1'b1};

   logic [STATE_BITS-1:0] state_ff, state_in;
   logic [TEMP_BITS-1:0]  held_ff, held_in;
   logic [TICK_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [TICK_BITS-1:0]  wait_ff, wait_in;
   logic                  clear_timing_ff, clear_timing_in;
   logic                  relay_ff, relay_in;
   logic                  blink_run_ff, blink_run_in;
   logic [TICK_BITS-1:0]  blink_count_ff, blink_count_in;
   logic                  led_ff, led_in;
   logic                  init_phase_ff, init_phase_in;

   logic [TICK_BITS-1:0]  elapsed_tick;
   logic [TICK_BITS-1:0]  blink_inc;
   logic [TICK_BITS-1:0]  period;
   logic                  low;
   logic                  expired;

   // One tick: hold the sample, advance the timers, then run the state machine.
   always_comb begin
      held_in = sample_valid ? temperature : held_ff;
      elapsed_tick = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TICK_ONE;
      elapsed_in = elapsed_tick;
      wait_in = wait_ff;
      clear_timing_in = clear_timing_ff;
      relay_in = relay_ff;
      blink_run_in = blink_run_ff;
      blink_count_in = blink_count_ff;
      led_in = led_ff;
      init_phase_in = init_phase_ff;
      state_in = state_ff;

      // Blink timer; a period of zero acts as one.
      period = (blink_interval == '0) ? TICK_ONE : blink_interval;
      blink_inc = blink_count_ff + TICK_ONE;
      if (blink_run_ff) begin
         if (blink_inc >= period) begin
            led_in = !led_ff;
            blink_count_in = '0;
         end else begin
            blink_count_in = blink_inc;
         end
      end

      low = held_in < setpoint;
      expired = elapsed_tick >= wait_ff;

      unique case (state_ff)
         ST_ABOVE: begin
            if (low) begin
               elapsed_in = '0;
               wait_in = alert_delay;
               init_phase_in = 1'b0;
               state_in = ST_LOW;
            end
         end
         ST_LOW: begin
            if (!low) begin
               state_in = ST_DEACTIVATE;
            end else if (expired) begin
               state_in = ST_ACTIVATE;
            end
         end
         ST_ACTIVATE: begin
            relay_in = 1'b0;
            blink_run_in = 1'b1;
            blink_count_in = '0;
            clear_timing_in = 1'b0;
            state_in = ST_LOW_WAIT;
         end
         ST_LOW_WAIT: begin
            if (low) begin
               clear_timing_in = 1'b0;
            end else if (!clear_timing_ff) begin
               elapsed_in = '0;
               wait_in = clear_delay;
               clear_timing_in = 1'b1;
            end else if (expired) begin
               state_in = ST_DEACTIVATE;
            end
         end
         ST_DEACTIVATE: begin
            clear_timing_in = 1'b0;
            relay_in = 1'b1;
            blink_run_in = 1'b0;
            blink_count_in = '0;
            led_in = 1'b0;
            state_in = ST_ABOVE;
         end
         default: begin
            state_in = ST_ABOVE;
         end
      endcase

      result.relay_closed = relay_in;
      result.alert_led = led_in;
      result.alarm_active = blink_run_in;
      result.state_code = state_in;
   end

   // State registers advance only on a tick that moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOW;
         held_ff         <= '0;
         elapsed_ff      <= '0;
         wait_ff         <= '0;
         clear_timing_ff <= 1'b0;
         relay_ff        <= 1'b0;
         blink_run_ff    <= 1'b0;
         blink_count_ff  <= '0;
         led_ff          <= 1'b0;
         init_phase_ff   <= 1'b1;
      end else if (step) begin
         state_ff        <= state_in;
         held_ff         <= held_in;
         elapsed_ff      <= elapsed_in;
         wait_ff         <= wait_in;
         clear_timing_ff <= clear_timing_in;
         relay_ff        <= relay_in;
         blink_run_ff    <= blink_run_in;
         blink_count_ff  <= blink_count_in;
         led_ff          <= led_in;
         init_phase_ff   <= init_phase_in;
      end else if (initial_delay_wr && init_phase_ff) begin
         wait_ff <= initial_delay;
      end
   end

endmodule

### design/setpoint_alarm_monitor.sv
// Setpoint alarm monitor. Each request is one monitor tick and may carry a new
// temperature sample (req_tuser high), which is held for later ticks. Every request
// yields exactly one response with the relay, LED, alarm and state levels after that
// tick. It takes one request per clock while rsp_tready is high; a response is
// registered (input register, then one pass of compare and counter logic into the
// result register), and stalls on rsp_tready back up through both registers without
// losing requests. Configuration registers are written through csr_we/csr_index/
// csr_wdata while no request is in flight, a user rule not enforced here; a write of
// the initial delay before the first alert delay is loaded also reloads the pending delay.
module setpoint_alarm_monitor #(
   parameter int TEMP_BITS = setalm_pkg::TEMP_BITS_DEFAULT,
   parameter int TICK_BITS = setalm_pkg::TICK_BITS_DEFAULT,
   parameter int REQ_DATA_BITS = ((TEMP_BITS + 7) / 8) * 8,
   parameter int CSR_DATA_BITS = (TEMP_BITS > TICK_BITS) ? TEMP_BITS : TICK_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [REQ_DATA_BITS-1:0]              req_tdata,  // temperature, pad ignored
   input  logic                                  req_tuser,  // sample_valid
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // relay_closed, alert_led, alarm_active, state_code[2:0], zero pad
   output logic [setalm_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                  csr_we,
   input  logic [setalm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]              csr_wdata
);
   import setalm_pkg::*;

   logic                 in_valid_ff;
   logic                 in_sample_ff;
   logic [TEMP_BITS-1:0] in_temp_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;
   result_type           result;
   logic                 step;

   logic [TEMP_BITS-1:0] setpoint;
   logic [TICK_BITS-1:0] initial_delay;
   logic [TICK_BITS-1:0] alert_delay;
   logic [TICK_BITS-1:0] clear_delay;
   logic [TICK_BITS-1:0] blink_interval;
   logic                 initial_delay_wr;

   setalm_csr #(
      .TEMP_BITS     (TEMP_BITS),
      .TICK_BITS     (TICK_BITS),
      .CSR_DATA_BITS (CSR_DATA_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .setpoint         (setpoint),
      .initial_delay    (initial_delay),
      .alert_delay      (alert_delay),
      .clear_delay      (clear_delay),
      .blink_interval   (blink_interval),
      .initial_delay_wr (initial_delay_wr)
   );

   // The held request moves on when the result register is empty or being drained.
   assign step = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   setalm_core #(
      .TEMP_BITS (TEMP_BITS),
      .TICK_BITS (TICK_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .sample_valid     (in_sample_ff),
      .temperature      (in_temp_ff),
      .setpoint         (setpoint),
      .initial_delay    (initial_delay),
      .alert_delay      (alert_delay),
      .clear_delay      (clear_delay),
      .blink_interval   (blink_interval),
      .initial_delay_wr (initial_delay_wr),
      .result           (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tuser;
         in_temp_ff   <= req_tdata[TEMP_BITS-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_BITS - RESULT_BITS){1'b0}}, rsp_data_ff};

`ifndef SYNTHESIS
   // Backpressure at the input only when both registers are occupied.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free register");

   // Above setpoint is only reached through deactivation, so the relay is closed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.state_code == ST_ABOVE) |->
      (rsp_data_ff.relay_closed && !rsp_data_ff.alarm_active && !rsp_data_ff.alert_led))
      else $error("above setpoint with the alarm outputs not cleared");

   // While waiting on a low reading the blink timer runs and the relay is open.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.state_code == ST_LOW_WAIT) |->
      (rsp_data_ff.alarm_active && !rsp_data_ff.relay_closed))
      else $error("low wait without an active alarm");

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff))
      else $error("result register changed under a stall");
`endif

endmodule

### tb/sv/tb_setpoint_alarm_monitor.sv
`timescale 1ns / 1ps

module tb_setpoint_alarm_monitor;
   import setalm_pkg::*;

   localparam int TEMP_BITS = TEMP_BITS_DEFAULT;
   localparam int TICK_BITS = TICK_BITS_DEFAULT;
   localparam int REQ_DATA_BITS = ((TEMP_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_BITS = (TEMP_BITS > TICK_BITS) ? TEMP_BITS : TICK_BITS;
   localparam logic [TEMP_BITS-1:0] TEMP_MAX = '1;
   localparam int MAX_IDLE = 10;
   localparam int PIPE_SETTLE = 4;
   localparam int WATCHDOG_LIMIT = 500;

   // Register indexes that the block does not decode.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] NO_REG = CSR_SETPOINT;
   localparam result_type NO_STATUS = '0;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   // One directed step: either a register write or a monitor tick.
   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic                     sample;
      logic [15:0]              data;
      logic                     known;
      result_type               want;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 30;

   // Expected status is given as {state, alarm_active, alert_led, relay_closed}.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Initial delay written after reset reloads the pending delay.
      '{ROW_WRITE, CSR_INITIAL_DELAY, 1'b0, 16'd3, 1'b0, NO_STATUS},
      // Setpoint upper bits beyond the temperature width are dropped.
      '{ROW_WRITE, CSR_SETPOINT, 1'b0, 16'hF800, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b1, 16'h0000, 1'b1, '{ST_LOW, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b1, '{ST_LOW, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b1, '{ST_ACTIVATE, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b1, '{ST_LOW_WAIT, 1'b1, 1'b0, 1'b0}},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b1, '{ST_LOW_WAIT, 1'b1, 1'b1, 1'b0}},
      // Full-scale temperature with the pad bits set.
      '{ROW_TICK, NO_REG, 1'b1, 16'hFFFF, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      // Short delays, a zero blink period and writes to undecoded indexes.
      '{ROW_WRITE, CSR_ALERT_DELAY, 1'b0, 16'd2, 1'b0, NO_STATUS},
      '{ROW_WRITE, CSR_CLEAR_DELAY, 1'b0, 16'd2, 1'b0, NO_STATUS},
      '{ROW_WRITE, CSR_BLINK_INTERVAL, 1'b0, 16'd0, 1'b0, NO_STATUS},
      '{ROW_WRITE, CSR_SPARE_LO, 1'b0, 16'hFFFF, 1'b0, NO_STATUS},
      '{ROW_WRITE, CSR_SPARE_HI, 1'b0, 16'hFFFF, 1'b0, NO_STATUS},
      // Just below, then exactly at the setpoint.
      '{ROW_TICK, NO_REG, 1'b1, 16'd2047, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b1, 16'd2048, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b1, 16'd2047, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      // Clear timing starts, is broken by a low reading, then restarts.
      '{ROW_TICK, NO_REG, 1'b1, 16'd2048, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b1, 16'd0, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b1, 16'd4095, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      '{ROW_TICK, NO_REG, 1'b0, 16'h0000, 1'b0, NO_STATUS},
      // A temperature without the sample flag must be ignored.
      '{ROW_TICK, NO_REG, 1'b0, 16'h0ABC, 1'b0, NO_STATUS}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;  // temperature, pad ignored
   logic req_tuser = 1'b0;                    // sample_valid
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // relay_closed, alert_led, alarm_active, state_code[2:0], zero pad
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Typed expectation travelling with the request, if the row has one.
   logic req_known = 1'b0;
   result_type req_want = '0;

   // Predicted monitor state and its copy of the registers.
   logic [TEMP_BITS-1:0] cfg_setpoint = '0;
   logic [TICK_BITS-1:0] cfg_initial = '0;
   logic [TICK_BITS-1:0] cfg_alert = '0;
   logic [TICK_BITS-1:0] cfg_clear = '0;
   logic [TICK_BITS-1:0] cfg_blink = TICK_BITS'(1);
   logic [STATE_BITS-1:0] mon_state = ST_LOW;
   logic [TEMP_BITS-1:0] held_temp = '0;
   logic [TICK_BITS-1:0] tick_count = '0;
   logic [TICK_BITS-1:0] pending_delay = '0;
   logic clearing = 1'b0;
   logic relay_q = 1'b0;
   logic blinking = 1'b0;
   logic [TICK_BITS-1:0] blink_ticks = '0;
   logic led_q = 1'b0;
   logic first_phase = 1'b1;

   result_type expected_status [$];
   result_type got_status;
   result_type want_status;
   result_type tick_status;
   int mismatches = 0;
   int quiet_cycles = 0;
   logic req_quiet = 1'b0;
   logic rsp_quiet = 1'b0;

   setpoint_alarm_monitor #(
      .TEMP_BITS(TEMP_BITS),
      .TICK_BITS(TICK_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one register write to the predicted configuration.
   task automatic apply_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      unique case (index)
         CSR_SETPOINT: cfg_setpoint = value[TEMP_BITS-1:0];
         CSR_INITIAL_DELAY: begin
            cfg_initial = value[TICK_BITS-1:0];
            // Until the first alert delay is loaded, the initial delay is live.
            if (first_phase) pending_delay = value[TICK_BITS-1:0];
         end
         CSR_ALERT_DELAY: cfg_alert = value[TICK_BITS-1:0];
         CSR_CLEAR_DELAY: cfg_clear = value[TICK_BITS-1:0];
         CSR_BLINK_INTERVAL: cfg_blink = value[TICK_BITS-1:0];
         default: ;
      endcase
   endtask

   // Advance the predicted monitor by one tick and return its status.
   function automatic result_type advance_tick(input logic sample,
                                               input logic [TEMP_BITS-1:0] temp);
      logic below;
      logic [TICK_BITS-1:0] period;
      logic [STATE_BITS-1:0] state_after;
      result_type status;
      if (sample) held_temp = temp;
      if (tick_count != '1) tick_count = tick_count + 1'b1;

      // The LED toggles each time the blink count reaches the period.
      if (blinking) begin
         period = (cfg_blink == '0) ? TICK_BITS'(1) : cfg_blink;
         blink_ticks = blink_ticks + 1'b1;
         if (blink_ticks >= period) begin
            led_q = !led_q;
            blink_ticks = '0;
         end
      end

      below = held_temp < cfg_setpoint;
      unique case (mon_state)
         ST_ABOVE: begin
            if (below) begin
               tick_count = '0;
               pending_delay = cfg_alert;
               first_phase = 1'b0;
               state_after = ST_LOW;
            end else begin
               state_after = ST_ABOVE;
            end
         end
         ST_LOW: begin
            if (!below) state_after = ST_DEACTIVATE;
            else if (tick_count >= pending_delay) state_after = ST_ACTIVATE;
            else state_after = ST_LOW;
         end
         ST_ACTIVATE: begin
            relay_q = 1'b0;
            blinking = 1'b1;
            blink_ticks = '0;
            clearing = 1'b0;
            state_after = ST_LOW_WAIT;
         end
         ST_LOW_WAIT: begin
            state_after = ST_LOW_WAIT;
            if (below) begin
               clearing = 1'b0;
            end else if (!clearing) begin
               tick_count = '0;
               pending_delay = cfg_clear;
               clearing = 1'b1;
            end else if (tick_count >= pending_delay) begin
               state_after = ST_DEACTIVATE;
            end
         end
         ST_DEACTIVATE: begin
            clearing = 1'b0;
            relay_q = 1'b1;
            blinking = 1'b0;
            blink_ticks = '0;
            led_q = 1'b0;
            state_after = ST_ABOVE;
         end
         default: state_after = ST_ABOVE;
      endcase
      mon_state = state_after;

      status.relay_closed = relay_q;
      status.alert_led = led_q;
      status.alarm_active = blinking;
      status.state_code = mon_state;
      return status;
   endfunction

   task automatic compare_field(input string field, input logic [2:0] want,
                                input logic [2:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Track register writes and requests, and check every response in order.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want_status = expected_status.pop_front();
               got_status = rsp_tdata[RESULT_BITS-1:0];
               compare_field("relay_closed", 3'(want_status.relay_closed),
                             3'(got_status.relay_closed));
               compare_field("alert_led", 3'(want_status.alert_led),
                             3'(got_status.alert_led));
               compare_field("alarm_active", 3'(want_status.alarm_active),
                             3'(got_status.alarm_active));
               compare_field("state_code", want_status.state_code,
                             got_status.state_code);
            end
         end
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            tick_status = advance_tick(req_tuser, req_tdata[TEMP_BITS-1:0]);
            expected_status.push_back(req_known ? req_want : tick_status);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   // End the run if nothing moves for too long.
   initial begin
      @(posedge clock);
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // The response side takes results after a random stall per result, or none when quiet.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Offer one tick request after a random gap, or none when quiet, and wait for it to be taken.
   task automatic drive_tick(input logic sample, input logic [REQ_DATA_BITS-1:0] data,
                             input logic known, input result_type want);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      csr_we <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= sample;
      req_tdata <= data;
      req_known <= known;
      req_want <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Wait until every request has produced its response and the pipe is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Mostly short delays, with zero, full scale and medium values mixed in.
   function automatic logic [TICK_BITS-1:0] pick_ticks();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return TICK_BITS'($urandom_range(7, 40));
         default: return TICK_BITS'($urandom_range(0, 6));
      endcase
   endfunction

   function automatic logic [TEMP_BITS-1:0] pick_setpoint();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return TEMP_MAX;
         2: return TEMP_BITS'(1);
         default: return TEMP_BITS'($urandom_range(1, TEMP_MAX));
      endcase
   endfunction

   // Reprogram all registers while the block is idle and pick the idling style.
   task automatic configure(input logic [TEMP_BITS-1:0] sp,
                            input logic [TICK_BITS-1:0] init_d,
                            input logic [TICK_BITS-1:0] alert_d,
                            input logic [TICK_BITS-1:0] clear_d,
                            input logic [TICK_BITS-1:0] blink_p);
      logic [CSR_DATA_BITS-1:0] word;
      settle();
      word = CSR_DATA_BITS'($urandom);
      word[TEMP_BITS-1:0] = sp;
      write_reg(CSR_SETPOINT, word);
      write_reg(CSR_INITIAL_DELAY, init_d);
      write_reg(CSR_ALERT_DELAY, alert_d);
      write_reg(CSR_CLEAR_DELAY, clear_d);
      write_reg(CSR_BLINK_INTERVAL, blink_p);
      if ($urandom_range(0, 1) != 0)
         write_reg(CSR_INDEX_BITS'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                   CSR_DATA_BITS'($urandom));
      req_quiet = ($urandom_range(0, 2) == 0);
      rsp_quiet = ($urandom_range(0, 2) == 0);
   endtask

   // Alternate runs of low and good readings so the delays can expire.
   task automatic run_random_phase(input int count);
      int left;
      logic low_run;
      logic fresh;
      logic sample;
      logic [TEMP_BITS-1:0] temp;
      logic [REQ_DATA_BITS-1:0] data;
      left = 0;
      low_run = 1'($urandom_range(0, 1));
      repeat (count) begin
         fresh = (left == 0);
         if (fresh) begin
            low_run = !low_run;
            left = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         end
         left--;
         if ($urandom_range(0, 9) == 0)
            temp = TEMP_BITS'($urandom_range(0, TEMP_MAX));
         else if (low_run && cfg_setpoint != 0)
            temp = ($urandom_range(0, 3) == 0) ? cfg_setpoint - 1'b1
                      : TEMP_BITS'($urandom_range(0, cfg_setpoint - 1));
         else
            temp = ($urandom_range(0, 3) == 0) ? cfg_setpoint
                      : TEMP_BITS'($urandom_range(cfg_setpoint, TEMP_MAX));
         sample = fresh || ($urandom_range(0, 2) != 0);
         data = REQ_DATA_BITS'($urandom);
         data[TEMP_BITS-1:0] = temp;
         drive_tick(sample, data, 1'b0, NO_STATUS);
      end
   endtask

   // Reset, directed table, random phases, then the verdict.
   initial begin
      stim_row_type row;
      logic busy;
      busy = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            if (busy) settle();
            busy = 1'b0;
            write_reg(row.index, row.data);
         end else begin
            drive_tick(row.sample, row.data, row.known, row.want);
            busy = 1'b1;
         end
      end

      configure(TEMP_MAX, '1, '1, '1, '1);
      run_random_phase(60);
      configure('0, '0, '0, '0, '0);
      run_random_phase(60);
      repeat (11) begin
         configure(pick_setpoint(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
         run_random_phase(120);
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
design/setalm_pkg.sv
design/setalm_csr.sv
design/setalm_core.sv
design/setpoint_alarm_monitor.sv
tb/sv/tb_setpoint_alarm_monitor.sv
